// ===== src/fmce_pkg.sv =====
// Shared types and constants for the framed memory command engine.
`timescale 1ns / 1ps
`default_nettype none
package fmce_pkg;

	localparam logic [7:0] CH_OPEN_REQ  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_REQ = 8'h5D;
	localparam logic [7:0] CH_OPEN_REP  = 8'h7B;
	localparam logic [7:0] CH_CLOSE_REP = 8'h7D;
	localparam logic [7:0] SUM_OK       = 8'hFF;
	localparam logic [7:0] HDR_LEN      = 8'd5;
	localparam logic [7:0] REP_LEN      = 8'd6;

	localparam logic [2:0] REG_READ_CODE  = 3'd0;
	localparam logic [2:0] REG_WRITE_CODE = 3'd1;
	localparam logic [2:0] REG_CALL_CODE  = 3'd2;
	localparam logic [2:0] REG_ERR_CODE   = 3'd3;
	localparam logic [2:0] REG_BAD_CODE   = 3'd4;
	localparam logic [2:0] REG_UNK_CODE   = 3'd5;

	localparam logic [2:0] RX_NONE = 3'd0;
	localparam logic [2:0] RX_LEN  = 3'd1;
	localparam logic [2:0] RX_ID   = 3'd2;
	localparam logic [2:0] RX_CMD  = 3'd3;
	localparam logic [2:0] RX_DATA = 3'd4;
	localparam logic [2:0] RX_SUM  = 3'd5;

	localparam logic [1:0] REP_NONE  = 2'd0;
	localparam logic [1:0] REP_READ  = 2'd1;
	localparam logic [1:0] REP_WRITE = 2'd2;
	localparam logic [1:0] REP_ERR   = 2'd3;

	localparam logic [2:0] E_OPEN  = 3'd0;
	localparam logic [2:0] E_LEN   = 3'd1;
	localparam logic [2:0] E_ID    = 3'd2;
	localparam logic [2:0] E_CODE  = 3'd3;
	localparam logic [2:0] E_MEM   = 3'd4;
	localparam logic [2:0] E_DBYTE = 3'd5;
	localparam logic [2:0] E_SUM   = 3'd6;
	localparam logic [2:0] E_CLOSE = 3'd7;

	typedef struct packed {
		logic [7:0] read_code;
		logic [7:0] write_code;
		logic [7:0] call_code;
		logic [7:0] err_code;
		logic [7:0] bad_code;
		logic [7:0] unk_code;
	} fmce_cfg_t;

	typedef struct packed {
		logic [2:0] rx_op;
		logic       ex_start;
		logic [1:0] reply_set;
		logic       err_unk;
		logic       emit;
		logic [2:0] emit_sel;
		logic       fr_rd;
		logic       addr_latch;
		logic       mem_rd;
		logic       mem_wr;
	} fmce_cmd_t;

	typedef struct packed {
		logic is_open;
		logic len_short;
		logic cnt_zero;
		logic idx_full;
		logic rx_last;
		logic end_ok;
		logic is_read;
		logic is_write;
		logic is_call;
		logic id_zero;
		logic n_odd;
		logic n_zero;
		logic idx_done;
		logic slot_bad;
		logic out_free;
	} fmce_stat_t;

endpackage
`default_nettype wire

// ===== src/fmce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fmce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/fmce_dp.sv =====
// Datapath: frame capture, command memory, reply byte assembly and output register.
`timescale 1ns / 1ps
`default_nettype none
module fmce_dp #(
	parameter int MAX_DATA = 32,
	parameter int MEM_DEPTH = 64,
	parameter int FUNCTION_SLOTS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fmce_pkg::fmce_cmd_t  cmd,
	input  wire fmce_pkg::fmce_cfg_t  cfg,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 out_ready,
	output fmce_pkg::fmce_stat_t      stat,
	output logic                      out_valid,
	output logic [7:0]                tx_byte,
	output logic                      last_byte
);

	localparam int IW  = $clog2(MAX_DATA + 1);
	localparam int FAW = $clog2(MAX_DATA);
	localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [7:0]    count_q, id_q, cmdb_q, sum_q, txsum_q, code_q, len_q, dbyte_q, addr_q;
	logic [IW-1:0] idx_q, n_q;
	logic          rvld_q;
	logic [MEM_DEPTH-1:0] vld_q;
	logic          out_valid_q, last_q;
	logic [7:0]    tx_q;

	logic [7:0]    fr_rdata, mem_rdata, ebyte;
	logic          fr_we, waddr_ok, raddr_ok;
	logic [IW-1:0] n_w;

	assign fr_we    = (cmd.rx_op == fmce_pkg::RX_DATA) && !stat.idx_full;
	assign waddr_ok = {1'b0, addr_q} < 9'(MEM_DEPTH);
	assign raddr_ok = {1'b0, fr_rdata} < 9'(MEM_DEPTH);
	assign n_w      = (count_q > 8'(MAX_DATA)) ? IW'(MAX_DATA) : count_q[IW-1:0];

	fmce_ram #(.WIDTH(8), .DEPTH(MAX_DATA)) u_frame (
		.clk  (clk),
		.we   (fr_we),
		.waddr(idx_q[FAW-1:0]),
		.wdata(rx_byte),
		.re   (cmd.fr_rd),
		.raddr(idx_q[FAW-1:0]),
		.rdata(fr_rdata)
	);

	fmce_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_bmem (
		.clk  (clk),
		.we   (cmd.mem_wr && waddr_ok),
		.waddr(addr_q[MAW-1:0]),
		.wdata(fr_rdata),
		.re   (cmd.mem_rd),
		.raddr(fr_rdata[MAW-1:0]),
		.rdata(mem_rdata)
	);

	always_comb begin
		stat.is_open   = rx_byte == fmce_pkg::CH_OPEN_REQ;
		stat.len_short = rx_byte < fmce_pkg::HDR_LEN;
		stat.cnt_zero  = count_q == 8'd0;
		stat.idx_full  = idx_q >= IW'(MAX_DATA);
		stat.rx_last   = ({1'b0, 8'(idx_q)} + 9'd1) >= {1'b0, count_q};
		stat.end_ok    = (rx_byte == fmce_pkg::CH_CLOSE_REQ) && (sum_q == fmce_pkg::SUM_OK);
		stat.is_read   = cmdb_q == cfg.read_code;
		stat.is_write  = cmdb_q == cfg.write_code;
		stat.is_call   = cmdb_q == cfg.call_code;
		stat.id_zero   = id_q == 8'd0;
		stat.n_odd     = n_q[0];
		stat.n_zero    = n_q == '0;
		stat.idx_done  = idx_q >= n_q;
		stat.slot_bad  = {1'b0, fr_rdata} >= 9'(FUNCTION_SLOTS);
		stat.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		case (cmd.emit_sel)
			fmce_pkg::E_OPEN:  ebyte = fmce_pkg::CH_OPEN_REP;
			fmce_pkg::E_LEN:   ebyte = len_q;
			fmce_pkg::E_ID:    ebyte = id_q;
			fmce_pkg::E_CODE:  ebyte = code_q;
			fmce_pkg::E_MEM:   ebyte = rvld_q ? mem_rdata : 8'h00;
			fmce_pkg::E_DBYTE: ebyte = dbyte_q;
			fmce_pkg::E_SUM:   ebyte = fmce_pkg::SUM_OK - txsum_q;
			default:           ebyte = fmce_pkg::CH_CLOSE_REP;
		endcase
	end

	// frame fields and reply bookkeeping
	always_ff @(posedge clk) begin
		case (cmd.rx_op)
			fmce_pkg::RX_LEN: begin
				if (!stat.len_short) begin
					count_q <= rx_byte - fmce_pkg::HDR_LEN;
					sum_q   <= rx_byte;
				end
			end
			fmce_pkg::RX_ID: begin
				id_q  <= rx_byte;
				sum_q <= sum_q + rx_byte;
			end
			fmce_pkg::RX_CMD: begin
				cmdb_q <= rx_byte;
				sum_q  <= sum_q + rx_byte;
			end
			fmce_pkg::RX_DATA: begin
				if (!stat.idx_full) begin
					sum_q <= sum_q + rx_byte;
				end
			end
			fmce_pkg::RX_SUM: sum_q <= sum_q + rx_byte;
			default: ;
		endcase

		if (cmd.rx_op == fmce_pkg::RX_CMD || cmd.ex_start) begin
			idx_q <= '0;
		end else if (fr_we || cmd.fr_rd) begin
			idx_q <= idx_q + IW'(1);
		end

		if (cmd.ex_start) begin
			n_q <= n_w;
		end

		if (cmd.addr_latch) begin
			addr_q <= fr_rdata;
		end
		if (cmd.mem_rd) begin
			rvld_q <= raddr_ok && vld_q[fr_rdata[MAW-1:0]];
		end

		if (cmd.ex_start) begin
			dbyte_q <= 8'd0;
		end else if (cmd.mem_wr) begin
			dbyte_q <= dbyte_q + 8'd1;
		end else if (cmd.reply_set == fmce_pkg::REP_ERR) begin
			dbyte_q <= cmd.err_unk ? cfg.unk_code : cfg.bad_code;
		end

		case (cmd.reply_set)
			fmce_pkg::REP_READ: begin
				code_q <= cfg.read_code;
				len_q  <= fmce_pkg::REP_LEN + 8'(n_q);
			end
			fmce_pkg::REP_WRITE: begin
				code_q <= cfg.write_code;
				len_q  <= fmce_pkg::REP_LEN + 8'd1;
			end
			fmce_pkg::REP_ERR: begin
				code_q <= cfg.err_code;
				len_q  <= fmce_pkg::REP_LEN + 8'd1;
			end
			default: ;
		endcase

		if (cmd.emit) begin
			tx_q   <= ebyte;
			last_q <= cmd.emit_sel == fmce_pkg::E_CLOSE;
			case (cmd.emit_sel)
				fmce_pkg::E_OPEN: txsum_q <= 8'd0;
				fmce_pkg::E_LEN, fmce_pkg::E_ID, fmce_pkg::E_CODE,
				fmce_pkg::E_MEM, fmce_pkg::E_DBYTE: txsum_q <= txsum_q + ebyte;
				default: ;
			endcase
		end
	end

	// written-entry marks stand in for the cleared memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mem_wr && waddr_ok) begin
				vld_q[addr_q[MAW-1:0]] <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_q;
	assign last_byte = last_q;

endmodule
`default_nettype wire

// ===== src/fmce_ctrl.sv =====
// Controller: receive phase tracking and command/reply sequencing.
`timescale 1ns / 1ps
`default_nettype none
module fmce_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 kind,
	input  wire fmce_pkg::fmce_stat_t stat,
	output logic                      in_ready,
	output fmce_pkg::fmce_cmd_t       cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_LEN   = 5'd1;
	localparam logic [4:0] S_ID    = 5'd2;
	localparam logic [4:0] S_CMD   = 5'd3;
	localparam logic [4:0] S_DATA  = 5'd4;
	localparam logic [4:0] S_SUM   = 5'd5;
	localparam logic [4:0] S_END   = 5'd6;
	localparam logic [4:0] S_EXEC  = 5'd7;
	localparam logic [4:0] S_HEAD  = 5'd8;
	localparam logic [4:0] S_DBYTE = 5'd9;
	localparam logic [4:0] S_RFR   = 5'd10;
	localparam logic [4:0] S_RMEM  = 5'd11;
	localparam logic [4:0] S_RDAT  = 5'd12;
	localparam logic [4:0] S_WA    = 5'd13;
	localparam logic [4:0] S_WB    = 5'd14;
	localparam logic [4:0] S_WW    = 5'd15;
	localparam logic [4:0] S_CCHK  = 5'd16;
	localparam logic [4:0] S_TAIL0 = 5'd17;
	localparam logic [4:0] S_TAIL1 = 5'd18;

	logic [4:0] state_q, state_d;
	logic [1:0] hc_q;
	logic       rmode_q, rmode_d;
	logic       fire;

	assign in_ready = state_q <= S_END;
	assign fire     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		rmode_d = rmode_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE, S_LEN, S_ID, S_CMD, S_DATA, S_SUM, S_END: begin
				if (fire) begin
					if (kind) begin
						state_d = S_IDLE;
					end else begin
						unique case (state_q)
							S_IDLE: if (stat.is_open) state_d = S_LEN;
							S_LEN: begin
								cmd.rx_op = fmce_pkg::RX_LEN;
								state_d = stat.len_short ? S_IDLE : S_ID;
							end
							S_ID: begin
								cmd.rx_op = fmce_pkg::RX_ID;
								state_d = S_CMD;
							end
							S_CMD: begin
								cmd.rx_op = fmce_pkg::RX_CMD;
								state_d = stat.cnt_zero ? S_SUM : S_DATA;
							end
							S_DATA: begin
								cmd.rx_op = fmce_pkg::RX_DATA;
								if (stat.idx_full) state_d = S_IDLE;
								else if (stat.rx_last) state_d = S_SUM;
							end
							S_SUM: begin
								cmd.rx_op = fmce_pkg::RX_SUM;
								state_d = S_END;
							end
							default: begin
								cmd.ex_start = stat.end_ok;
								state_d = stat.end_ok ? S_EXEC : S_IDLE;
							end
						endcase
					end
				end
			end
			S_EXEC: begin
				rmode_d = 1'b0;
				state_d = S_IDLE;
				if (stat.is_read) begin
					if (!stat.id_zero) begin
						cmd.reply_set = fmce_pkg::REP_READ;
						rmode_d = 1'b1;
						state_d = S_HEAD;
					end
				end else if (stat.is_write) begin
					if (!stat.n_odd) begin
						state_d = S_WA;
					end else if (!stat.id_zero) begin
						cmd.reply_set = fmce_pkg::REP_ERR;
						state_d = S_HEAD;
					end
				end else if (stat.is_call) begin
					if (!stat.n_zero) begin
						cmd.fr_rd = 1'b1;
						state_d = S_CCHK;
					end else if (!stat.id_zero) begin
						cmd.reply_set = fmce_pkg::REP_ERR;
						state_d = S_HEAD;
					end
				end
			end
			S_CCHK: begin
				state_d = S_IDLE;
				if (!stat.id_zero) begin
					cmd.reply_set = fmce_pkg::REP_ERR;
					cmd.err_unk = !stat.slot_bad;
					state_d = S_HEAD;
				end
			end
			S_WA: begin
				if (stat.idx_done) begin
					state_d = S_IDLE;
					if (!stat.id_zero) begin
						cmd.reply_set = fmce_pkg::REP_WRITE;
						state_d = S_HEAD;
					end
				end else begin
					cmd.fr_rd = 1'b1;
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.addr_latch = 1'b1;
				cmd.fr_rd = 1'b1;
				state_d = S_WW;
			end
			S_WW: begin
				cmd.mem_wr = 1'b1;
				state_d = S_WA;
			end
			S_HEAD: begin
				case (hc_q)
					2'd0:    cmd.emit_sel = fmce_pkg::E_OPEN;
					2'd1:    cmd.emit_sel = fmce_pkg::E_LEN;
					2'd2:    cmd.emit_sel = fmce_pkg::E_ID;
					default: cmd.emit_sel = fmce_pkg::E_CODE;
				endcase
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (hc_q == 2'd3) begin
						if (!rmode_q) state_d = S_DBYTE;
						else state_d = stat.n_zero ? S_TAIL0 : S_RFR;
					end
				end
			end
			S_DBYTE: begin
				cmd.emit_sel = fmce_pkg::E_DBYTE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_TAIL0;
				end
			end
			S_RFR: begin
				cmd.fr_rd = 1'b1;
				state_d = S_RMEM;
			end
			S_RMEM: begin
				cmd.mem_rd = 1'b1;
				state_d = S_RDAT;
			end
			S_RDAT: begin
				cmd.emit_sel = fmce_pkg::E_MEM;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = stat.idx_done ? S_TAIL0 : S_RFR;
				end
			end
			S_TAIL0: begin
				cmd.emit_sel = fmce_pkg::E_SUM;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_TAIL1;
				end
			end
			S_TAIL1: begin
				cmd.emit_sel = fmce_pkg::E_CLOSE;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hc_q    <= 2'd0;
			rmode_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rmode_q <= rmode_d;
			if (state_q == S_HEAD && cmd.emit) begin
				hc_q <= hc_q + 2'd1;
			end else if (state_q != S_HEAD) begin
				hc_q <= 2'd0;
			end
		end
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free) else $error("beat emitted over a pending beat");
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fr_rd |-> !stat.idx_full) else $error("frame read past buffer");
	a_mem_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_rd |=> state_q == S_RDAT) else $error("memory read not followed by data");
	a_close_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_sel == fmce_pkg::E_CLOSE) |=> state_q == S_IDLE)
		else $error("reply close did not return to idle");
`endif

endmodule
`default_nettype wire

// ===== src/framed_memory_command_engine_core.sv =====
// Top level: configuration registers, controller and datapath.
// Receive: one input beat per cycle; input stalls from the end byte until the reply is out.
// The reply follows the end byte via S_EXEC and S_HEAD (a call with data adds S_CCHK,
// a write S_WA, S_WB, S_WW per pair); each read data byte passes S_RFR, S_RMEM, S_RDAT.
// Every reply beat waits on out_ready.
// Reset: asynchronous, active low; config registers return to defaults, memory reads as zero.
`timescale 1ns / 1ps
`default_nettype none
module framed_memory_command_engine_core #(
	parameter int MAX_DATA = 32,
	parameter int MEM_DEPTH = 64,
	parameter int FUNCTION_SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       tx_byte,
	output logic             last_byte,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	fmce_pkg::fmce_cfg_t  cfg_q;
	fmce_pkg::fmce_cmd_t  cmd;
	fmce_pkg::fmce_stat_t stat;
	logic [2:0]           ridx;
	logic [7:0]           rval;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_code  <= 8'd1;
			cfg_q.write_code <= 8'd2;
			cfg_q.call_code  <= 8'd3;
			cfg_q.err_code   <= 8'd255;
			cfg_q.bad_code   <= 8'd1;
			cfg_q.unk_code   <= 8'd2;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				fmce_pkg::REG_READ_CODE:  cfg_q.read_code  <= pwdata[7:0];
				fmce_pkg::REG_WRITE_CODE: cfg_q.write_code <= pwdata[7:0];
				fmce_pkg::REG_CALL_CODE:  cfg_q.call_code  <= pwdata[7:0];
				fmce_pkg::REG_ERR_CODE:   cfg_q.err_code   <= pwdata[7:0];
				fmce_pkg::REG_BAD_CODE:   cfg_q.bad_code   <= pwdata[7:0];
				fmce_pkg::REG_UNK_CODE:   cfg_q.unk_code   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			fmce_pkg::REG_READ_CODE:  rval = cfg_q.read_code;
			fmce_pkg::REG_WRITE_CODE: rval = cfg_q.write_code;
			fmce_pkg::REG_CALL_CODE:  rval = cfg_q.call_code;
			fmce_pkg::REG_ERR_CODE:   rval = cfg_q.err_code;
			fmce_pkg::REG_BAD_CODE:   rval = cfg_q.bad_code;
			fmce_pkg::REG_UNK_CODE:   rval = cfg_q.unk_code;
			default:                  rval = 8'd0;
		endcase
	end
	assign prdata = {24'd0, rval};

	fmce_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.kind    (kind),
		.stat    (stat),
		.in_ready(in_ready),
		.cmd     (cmd)
	);

	fmce_dp #(
		.MAX_DATA      (MAX_DATA),
		.MEM_DEPTH     (MEM_DEPTH),
		.FUNCTION_SLOTS(FUNCTION_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.rx_byte  (rx_byte),
		.out_ready(out_ready),
		.stat     (stat),
		.out_valid(out_valid),
		.tx_byte  (tx_byte),
		.last_byte(last_byte)
	);

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the framed memory command engine core.
`timescale 1ns / 1ps
module testbench;

	typedef logic [7:0] u8_t;
	typedef u8_t u8_q_t[$];

	typedef struct {
		u8_t b;
		bit  last;
	} reply_beat_t;

	typedef enum int {P_IDLE, P_LEN, P_ID, P_CMD, P_DATA, P_SUM, P_END} frame_phase_t;

	localparam int FRAME_DATA_MAX = 32;
	localparam int MEM_WORDS      = 64;
	localparam int SLOTS          = 8;
	localparam int QUIET_LIMIT    = 20000;
	localparam int DRAIN_CYCLES   = 200;

	localparam int FR_GOOD    = 0;
	localparam int FR_BAD_SUM = 1;
	localparam int FR_BAD_END = 2;
	localparam int FR_ABORT   = 3;

	class reply_scoreboard_t;
		u8_t read_code, write_code, call_code, err_code, bad_code, unk_code;
		frame_phase_t phase;
		u8_t data_cnt, req_id, req_cmd, rx_sum, tx_sum;
		int data_idx;
		u8_t frame_buf[FRAME_DATA_MAX];
		u8_t mem[MEM_WORDS];
		reply_beat_t pending[$];
		int fails;

		function new();
			read_code = 1; write_code = 2; call_code = 3;
			err_code = 255; bad_code = 1; unk_code = 2;
			phase = P_IDLE;
			data_cnt = 0; req_id = 0; req_cmd = 0; rx_sum = 0; data_idx = 0;
			foreach (mem[i]) mem[i] = 8'd0;
			fails = 0;
		endfunction

		function void put(u8_t b, bit last);
			reply_beat_t r;
			r.b = b;
			r.last = last;
			pending.push_back(r);
		endfunction

		function void head(u8_t code, int n);
			u8_t len;
			len = u8_t'(6 + n);
			put(fmce_pkg::CH_OPEN_REP, 0); put(len, 0); put(req_id, 0); put(code, 0);
			tx_sum = len + req_id + code;
		endfunction

		function void body(u8_t b);
			put(b, 0);
			tx_sum = tx_sum + b;
		endfunction

		function void tail();
			put(fmce_pkg::SUM_OK - tx_sum, 0);
			put(fmce_pkg::CH_CLOSE_REP, 1);
		endfunction

		function void error_reply(u8_t code);
			if (req_id == 0) return;
			head(err_code, 1);
			body(code);
			tail();
		endfunction

		function void run_command();
			int n;
			u8_t pairs;
			n = (data_cnt > FRAME_DATA_MAX) ? FRAME_DATA_MAX : data_cnt;
			if (req_cmd == read_code) begin
				if (req_id == 0) return;
				head(read_code, n);
				for (int i = 0; i < n; i++)
					body(frame_buf[i] < MEM_WORDS ? mem[frame_buf[i]] : 8'd0);
				tail();
			end else if (req_cmd == write_code) begin
				if (n % 2) begin
					error_reply(bad_code);
					return;
				end
				pairs = 0;
				for (int i = 0; i + 1 < n; i += 2) begin
					if (frame_buf[i] < MEM_WORDS) mem[frame_buf[i]] = frame_buf[i + 1];
					pairs++;
				end
				if (req_id == 0) return;
				head(write_code, 1);
				body(pairs);
				tail();
			end else if (req_cmd == call_code) begin
				if (n < 1 || frame_buf[0] >= SLOTS) error_reply(bad_code);
				else error_reply(unk_code);
			end
		endfunction

		// Note one accepted input beat and queue the reply bytes it causes.
		function void note_beat(bit timeout, u8_t c);
			if (timeout) begin
				phase = P_IDLE;
				return;
			end
			case (phase)
				P_IDLE: if (c == fmce_pkg::CH_OPEN_REQ) phase = P_LEN;
				P_LEN: begin
					if (c < fmce_pkg::HDR_LEN) phase = P_IDLE;
					else begin
						data_cnt = c - fmce_pkg::HDR_LEN;
						rx_sum = c;
						phase = P_ID;
					end
				end
				P_ID: begin
					req_id = c; rx_sum += c; phase = P_CMD;
				end
				P_CMD: begin
					req_cmd = c; rx_sum += c; data_idx = 0;
					phase = (data_cnt == 0) ? P_SUM : P_DATA;
				end
				P_DATA: begin
					if (data_idx >= FRAME_DATA_MAX) phase = P_IDLE;
					else begin
						frame_buf[data_idx] = c;
						rx_sum += c;
						data_idx++;
						if (data_idx >= data_cnt) phase = P_SUM;
					end
				end
				P_SUM: begin
					rx_sum += c; phase = P_END;
				end
				default: begin
					phase = P_IDLE;
					if (c == fmce_pkg::CH_CLOSE_REQ && rx_sum == fmce_pkg::SUM_OK)
						run_command();
				end
			endcase
		endfunction

		function void check_beat(u8_t b, bit last);
			reply_beat_t e;
			if (pending.size() == 0) begin
				if (fails < 10) $display("unexpected reply beat: tx_byte=%h last_byte=%b", b, last);
				fails++;
				return;
			end
			e = pending.pop_front();
			if (e.b !== b || e.last !== last) begin
				if (fails < 10)
					$display("reply mismatch: expected %h/%b, got %h/%b", e.b, e.last, b, last);
				fails++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, kind = 0, out_ready = 0;
	logic [7:0] rx_byte = 0;
	logic in_ready, out_valid, last_byte, pready;
	logic [7:0] tx_byte;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;

	reply_scoreboard_t sb = new();
	int quiet = 0;
	int phase_beats = 0;
	int out_stall = 0;
	bit tx_calm = 0, rx_calm = 0;

	framed_memory_command_engine_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready), .tx_byte(tx_byte),
		.last_byte(last_byte),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Receiver: stall at random, with calm stretches now and then.
	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_ready = 0;
			out_stall--;
		end else begin
			out_ready = 1;
			if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
			if (!rx_calm && $urandom_range(0, 3) == 0) out_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_beat(tx_byte, last_byte);
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL framed_memory_command_engine_core");
			$finish;
		end
	end

	task automatic send_beat(input bit timeout, input u8_t c);
		int g;
		g = tx_calm ? 0 : pick_gap();
		repeat (g) @(negedge clk);
		in_valid = 1;
		kind = timeout;
		rx_byte = c;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		sb.note_beat(timeout, c);
		phase_beats++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic send_frame(input u8_t id, input u8_t cmd, input u8_q_t d, input int mode);
		u8_t len, s;
		int cut;
		len = u8_t'(5 + d.size());
		s = len + id + cmd;
		foreach (d[i]) s += d[i];
		cut = (mode == FR_ABORT) ? $urandom_range(1, 4 + d.size()) : 99999;
		send_beat(0, fmce_pkg::CH_OPEN_REQ);
		if (cut == 1) begin send_beat(1, u8_t'($urandom)); return; end
		send_beat(0, len);
		if (cut == 2) begin send_beat(1, u8_t'($urandom)); return; end
		send_beat(0, id);
		if (cut == 3) begin send_beat(1, u8_t'($urandom)); return; end
		send_beat(0, cmd);
		foreach (d[i]) begin
			if (cut == 4 + i) begin send_beat(1, u8_t'($urandom)); return; end
			send_beat(0, d[i]);
		end
		if (mode == FR_ABORT) begin send_beat(1, u8_t'($urandom)); return; end
		send_beat(0, fmce_pkg::SUM_OK - s + (mode == FR_BAD_SUM ? 8'd1 : 8'd0));
		send_beat(0, mode == FR_BAD_END ? 8'h5C : fmce_pkg::CH_CLOSE_REQ);
	endtask

	task automatic wait_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input u8_t val);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0;
		paddr = {idx, 2'b00};
		pwdata = {24'd0, val};
		@(negedge clk);
		penable = 1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		case (idx)
			fmce_pkg::REG_READ_CODE:  sb.read_code = val;
			fmce_pkg::REG_WRITE_CODE: sb.write_code = val;
			fmce_pkg::REG_CALL_CODE:  sb.call_code = val;
			fmce_pkg::REG_ERR_CODE:   sb.err_code = val;
			fmce_pkg::REG_BAD_CODE:   sb.bad_code = val;
			default:                  sb.unk_code = val;
		endcase
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic config_all(input u8_t rd, wr, cl, er, bd, uk);
		wait_idle();
		reg_write(fmce_pkg::REG_READ_CODE, rd);
		reg_write(fmce_pkg::REG_WRITE_CODE, wr);
		reg_write(fmce_pkg::REG_CALL_CODE, cl);
		reg_write(fmce_pkg::REG_ERR_CODE, er);
		reg_write(fmce_pkg::REG_BAD_CODE, bd);
		reg_write(fmce_pkg::REG_UNK_CODE, uk);
	endtask

	function automatic u8_t pick_addr();
		return ($urandom_range(0, 4) == 0) ? u8_t'($urandom) : u8_t'($urandom_range(0, 63));
	endfunction

	// Mostly well-formed frames with random content; the rest noise and broken frames.
	task automatic random_traffic(input int beats, input bit pause_once);
		u8_q_t d;
		u8_t cmd;
		int n, r, mode;
		bit paused;
		paused = 0;
		phase_beats = 0;
		while (phase_beats < beats) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_beat(bit'($urandom_range(0, 1)), u8_t'($urandom));
				continue;
			end
			case ($urandom_range(0, 5))
				0, 1: cmd = sb.read_code;
				2, 3: cmd = sb.write_code;
				4:    cmd = sb.call_code;
				default: cmd = u8_t'($urandom);
			endcase
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 8);
			if (cmd == sb.write_code && $urandom_range(0, 4) != 0) n = n & ~1;
			d = {};
			for (int i = 0; i < n; i++)
				d.push_back((i % 2 == 0 || cmd != sb.write_code) ? pick_addr() : u8_t'($urandom));
			if (cmd == sb.call_code && n > 0 && $urandom_range(0, 1))
				d[0] = u8_t'($urandom_range(0, 9));
			r = $urandom_range(0, 99);
			mode = (r < 82) ? FR_GOOD : (r < 88) ? FR_BAD_SUM : (r < 94) ? FR_BAD_END : FR_ABORT;
			send_frame(($urandom_range(0, 9) == 0) ? 8'd0 : u8_t'($urandom), cmd, d, mode);
			if (pause_once && !paused) begin
				paused = 1;
				while (sb.pending.size() != 0) @(posedge clk);
			end
		end
		tx_calm = 0;
	endtask

	initial begin
		u8_q_t d;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: memory, parameter errors, function calls and framing faults.
		send_frame(1, 2, '{8'h00, 8'hAA, 8'h3F, 8'h55, 8'h40, 8'h12, 8'hFF, 8'h01}, FR_GOOD);
		send_frame(2, 1, '{8'h00, 8'h3F, 8'h40, 8'hFF, 8'h05}, FR_GOOD);
		send_frame(3, 2, '{8'h01, 8'h02, 8'h03}, FR_GOOD);
		send_frame(4, 3, '{}, FR_GOOD);
		send_frame(5, 3, '{8'h07}, FR_GOOD);
		send_frame(6, 3, '{8'h08}, FR_GOOD);
		send_frame(7, 8'h77, '{8'h01}, FR_GOOD);
		send_frame(0, 2, '{8'h0A, 8'h33}, FR_GOOD);
		send_frame(8'hFF, 1, '{8'h0A}, FR_GOOD);
		send_frame(9, 1, '{}, FR_GOOD);
		send_frame(10, 1, '{8'h0A}, FR_BAD_SUM);
		send_frame(11, 1, '{8'h0A}, FR_BAD_END);
		send_frame(12, 1, '{8'h0A, 8'h00}, FR_ABORT);
		send_beat(0, fmce_pkg::CH_OPEN_REQ); send_beat(0, 8'd4); send_beat(0, 8'h11);
		send_beat(0, 8'h00); send_beat(1, 8'h00); send_beat(0, 8'hFF);
		d = {};
		for (int i = 0; i < 33; i++) d.push_back(u8_t'(i));
		send_frame(13, 1, d, FR_GOOD);
		d = {};
		for (int i = 0; i < 32; i++) d.push_back(u8_t'(i * 2));
		send_frame(14, 1, d, FR_GOOD);

		random_traffic(8, 1);
		config_all(u8_t'($urandom), u8_t'($urandom), u8_t'($urandom),
			u8_t'($urandom), u8_t'($urandom), u8_t'($urandom));
		random_traffic(4, 0);
		// Extremes; read and call coincide, so read wins.
		config_all(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
		random_traffic(4, 0);
		config_all(8'h80, 8'h80, 8'h81, 8'h7F, 8'h55, 8'hAA);
		random_traffic(4, 0);

		wait_idle();
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("PASS framed_memory_command_engine_core");
		else
			$display("FAIL framed_memory_command_engine_core");
		$finish;
	end
endmodule
